// ----- hw/rtl/dlawg_pkg.sv -----
package dlawg_pkg;

  // Default grid limits handed to the top level.
  localparam int DEF_MAX_COLS = 256;
  localparam int DEF_MAX_ROWS = 256;

  localparam int COORD_W  = 8;
  localparam int DIM_W    = 9;
  localparam int COUNT_W  = 16;
  localparam int VAL_W    = 8;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  // Request codes; the unused code behaves as a read.
  localparam logic [1:0] REQ_SEED = 2'd0;
  localparam logic [1:0] REQ_WALK = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  // Walk directions.
  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_UP    = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  // Result status codes.
  localparam logic [2:0] STAT_MOVED         = 3'd0;
  localparam logic [2:0] STAT_LANDED        = 3'd1;
  localparam logic [2:0] STAT_HELD          = 3'd2;
  localparam logic [2:0] STAT_LANDED_INSIDE = 3'd3;
  localparam logic [2:0] STAT_SEEDED        = 3'd4;
  localparam logic [2:0] STAT_READ          = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_POINTS = 2'd2;

  localparam logic [DIM_W-1:0]   RST_GRID_WIDTH   = 9'd256;
  localparam logic [DIM_W-1:0]   RST_GRID_HEIGHT  = 9'd256;
  localparam logic [COUNT_W-1:0] RST_TOTAL_POINTS = 16'd1000;

  localparam logic [DIM_W-1:0] MIN_DIM   = 9'd3;
  localparam logic [VAL_W-1:0] CELL_FULL = 8'd255;
  localparam logic [VAL_W-1:0] BLUE_TOP  = 8'd254;

  // Landing value divider request and response.
  typedef struct packed {
    logic               start;
    logic [COUNT_W-1:0] landed;
    logic [COUNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- hw/rtl/dlawg_div.sv -----
module dlawg_div (
  input  logic                clk,
  input  logic                rst_n,
  input  dlawg_pkg::div_req_t req,
  output dlawg_pkg::div_rsp_t rsp
);
  import dlawg_pkg::*;

  localparam int NUM_W = COUNT_W + VAL_W;

  typedef enum logic {D_IDLE, D_RUN} dstate_t;

  dstate_t            state_r;
  logic [NUM_W-1:0]   rem_r;
  logic [NUM_W-1:0]   dsh_r;
  logic [VAL_W-1:0]   q_r;
  logic [2:0]         cnt_r;
  logic               done_r;

  logic [NUM_W-1:0] num;
  logic [NUM_W-1:0] top;
  logic             ge;

  // The dividend is 255 times the landed count; a quotient of 256 or more saturates.
  assign num = {req.landed, {VAL_W{1'b0}}} - NUM_W'(req.landed);
  assign top = {req.divisor, {VAL_W{1'b0}}};
  assign ge  = (rem_r >= dsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        D_IDLE: begin
          if (req.start) begin
            if (num >= top) begin
              q_r    <= CELL_FULL;
              done_r <= 1'b1;
            end else begin
              rem_r   <= num;
              dsh_r   <= {1'b0, req.divisor, {(VAL_W-1){1'b0}}};
              cnt_r   <= 3'd7;
              state_r <= D_RUN;
            end
          end
        end
        D_RUN: begin
          // One restoring step per cycle, most significant quotient bit first.
          if (ge) begin
            rem_r <= rem_r - dsh_r;
          end
          dsh_r <= dsh_r >> 1;
          q_r   <= {q_r[VAL_W-2:0], ge};
          cnt_r <= cnt_r - 3'd1;
          if (cnt_r == 3'd0) begin
            done_r  <= 1'b1;
            state_r <= D_IDLE;
          end
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

endmodule

// ----- hw/rtl/dla_walker_grid_engine.sv -----
// Diffusion-limited aggregation engine on a byte grid held in one on-chip memory.
// Input words arrive on in_valid/in_stall and carry a request: place a seed, take
// one walk step of the single walker, or read a cell with its colour. Each input
// word produces exactly one output word on out_valid/out_stall. The grid size and
// the planned walker count are written through cfg_we/cfg_index/cfg_wdata; the user
// must do so while idle, which the block itself does not enforce. Words are handled
// one at a time; each costs one memory read per cell inspected. A seed is written
// after the neighbour test without a read; a read or a held step reads one cell; a
// move reads the walker's cell and then its neighbour; a landing reads the walker's
// cell (inside) or both cells (beside), then waits for the landing divider, which
// saturates without dividing or else forms the quotient bit-serially. The next word
// is taken after the result is registered. The memory port reads one cell per cycle.
// After reset the engine runs a clearing pass that writes zero into every memory
// entry, one per cycle; there are 2**(clog2(cols)+clog2(rows)) entries, 65536 by default.
// in_stall stays high during the pass; configuration writes are taken meanwhile.
// The result sits in an output register. While the receiver stalls, the engine
// still accepts the next word and works on it, then waits before overwriting.
module dla_walker_grid_engine #(
  parameter int MAX_COLS = dlawg_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = dlawg_pkg::DEF_MAX_ROWS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_req_type,
  input  logic [dlawg_pkg::COORD_W-1:0]   in_pos_x,
  input  logic [dlawg_pkg::COORD_W-1:0]   in_pos_y,
  input  logic [1:0]                      in_direction,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      out_status,
  output logic [dlawg_pkg::COORD_W-1:0]   out_walker_col,
  output logic [dlawg_pkg::COORD_W-1:0]   out_walker_row,
  output logic [dlawg_pkg::VAL_W-1:0]     out_cell_value,
  output logic [dlawg_pkg::VAL_W-1:0]     out_red,
  output logic [dlawg_pkg::VAL_W-1:0]     out_green,
  output logic [dlawg_pkg::VAL_W-1:0]     out_blue,
  output logic [dlawg_pkg::COUNT_W-1:0]   out_landed_so_far,
  input  logic                            cfg_we,
  input  logic [dlawg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dlawg_pkg::CFG_W-1:0]     cfg_wdata
);
  import dlawg_pkg::*;

  // Coordinates are bytes, so the usable grid never exceeds 256 in either direction.
  localparam int LIM_COLS = (MAX_COLS < 256) ? MAX_COLS : 256;
  localparam int LIM_ROWS = (MAX_ROWS < 256) ? MAX_ROWS : 256;
  localparam int CB       = $clog2(LIM_COLS);
  localparam int RB       = $clog2(LIM_ROWS);
  localparam int ADDR_W   = CB + RB;
  localparam int DEPTH    = 1 << ADDR_W;
  localparam logic [DIM_W-1:0] LIM_COLS_D = DIM_W'(LIM_COLS);
  localparam logic [DIM_W-1:0] LIM_ROWS_D = DIM_W'(LIM_ROWS);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_LOOK, ST_OWN, ST_NBR, ST_DIV, ST_DONE
  } state_t;

  // Grid memory: one write and one registered read per cycle.
  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rdata_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [VAL_W-1:0]  mem_wdata;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  state_t state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic [DIM_W-1:0]   grid_width_r, grid_width_nxt;
  logic [DIM_W-1:0]   grid_height_r, grid_height_nxt;
  logic [COUNT_W-1:0] total_points_r, total_points_nxt;
  logic [COORD_W-1:0] walker_x_r, walker_x_nxt;
  logic [COORD_W-1:0] walker_y_r, walker_y_nxt;
  logic               walker_active_r, walker_active_nxt;
  logic [COUNT_W-1:0] landed_r, landed_nxt;
  logic [1:0]         req_r, req_nxt;
  logic [1:0]         dir_r, dir_nxt;
  logic [COORD_W-1:0] cur_x_r, cur_x_nxt;
  logic [COORD_W-1:0] cur_y_r, cur_y_nxt;
  logic [COORD_W-1:0] nx_r, nx_nxt;
  logic [COORD_W-1:0] ny_r, ny_nxt;
  logic               held_r, held_nxt;
  logic [VAL_W-1:0]   val_r, val_nxt;
  logic [2:0]         stat_r, stat_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         out_status_r, out_status_nxt;
  logic [COORD_W-1:0] out_col_r, out_col_nxt;
  logic [COORD_W-1:0] out_row_r, out_row_nxt;
  logic [VAL_W-1:0]   out_val_r, out_val_nxt;
  logic [VAL_W-1:0]   out_red_r, out_red_nxt;
  logic [VAL_W-1:0]   out_green_r, out_green_nxt;
  logic [VAL_W-1:0]   out_blue_r, out_blue_nxt;
  logic [COUNT_W-1:0] out_landed_r, out_landed_nxt;

  logic [DIM_W-1:0]   w_eff, h_eff;
  logic [COUNT_W-1:0] tp_eff;
  logic [COORD_W-1:0] px_sat, py_sat, wx_sat, wy_sat;
  logic               accept;
  logic [9:0]         p3;
  logic [VAL_W-1:0]   red_c, green_c, blue_c;

  div_req_t div_req;
  div_rsp_t div_rsp;

  dlawg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Saturate a coordinate to the last column or row in use.
  function automatic logic [COORD_W-1:0] sat_coord(input logic [COORD_W-1:0] v,
                                                   input logic [DIM_W-1:0] n);
    logic [DIM_W-1:0] nm1;
    nm1 = n - DIM_W'(1);
    return ({1'b0, v} >= n) ? nm1[COORD_W-1:0] : v;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                  input logic [COORD_W-1:0] y);
    return {y[RB-1:0], x[CB-1:0]};
  endfunction

  // Effective grid size, clamped into the supported range.
  always_comb begin
    if (grid_width_r < MIN_DIM) begin
      w_eff = MIN_DIM;
    end else if (grid_width_r > LIM_COLS_D) begin
      w_eff = LIM_COLS_D;
    end else begin
      w_eff = grid_width_r;
    end
    if (grid_height_r < MIN_DIM) begin
      h_eff = MIN_DIM;
    end else if (grid_height_r > LIM_ROWS_D) begin
      h_eff = LIM_ROWS_D;
    end else begin
      h_eff = grid_height_r;
    end
  end

  assign tp_eff = (total_points_r == '0) ? COUNT_W'(1) : total_points_r;

  // A spawn only happens without an active walker; an active walker is pulled
  // back inside when the grid has shrunk.
  assign px_sat = sat_coord(in_pos_x, w_eff);
  assign py_sat = sat_coord(in_pos_y, h_eff);
  assign wx_sat = sat_coord(walker_active_r ? walker_x_r : in_pos_x, w_eff);
  assign wy_sat = sat_coord(walker_active_r ? walker_y_r : in_pos_y, h_eff);

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Colour of the finished cell value: p3 = 3 * (255 - value).
  assign p3 = {1'b0, ~val_r, 1'b0} + {2'b00, ~val_r};

  always_comb begin
    if (val_r == '0) begin
      red_c   = '0;
      green_c = '0;
      blue_c  = '0;
    end else begin
      red_c   = (p3 >= 10'd255) ? CELL_FULL : p3[VAL_W-1:0];
      green_c = (p3 > 10'd510) ? 8'(p3 - 10'd510) : '0;
      if (p3 <= 10'd255) begin
        blue_c = '0;
      end else if (p3 >= 10'd510) begin
        blue_c = BLUE_TOP;
      end else begin
        blue_c = 8'(p3 - 10'd255);
      end
    end
  end

  always_comb begin
    state_nxt         = state_r;
    clr_addr_nxt      = clr_addr_r;
    grid_width_nxt    = grid_width_r;
    grid_height_nxt   = grid_height_r;
    total_points_nxt  = total_points_r;
    walker_x_nxt      = walker_x_r;
    walker_y_nxt      = walker_y_r;
    walker_active_nxt = walker_active_r;
    landed_nxt        = landed_r;
    req_nxt           = req_r;
    dir_nxt           = dir_r;
    cur_x_nxt         = cur_x_r;
    cur_y_nxt         = cur_y_r;
    nx_nxt            = nx_r;
    ny_nxt            = ny_r;
    held_nxt          = held_r;
    val_nxt           = val_r;
    stat_nxt          = stat_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_status_nxt    = out_status_r;
    out_col_nxt       = out_col_r;
    out_row_nxt       = out_row_r;
    out_val_nxt       = out_val_r;
    out_red_nxt       = out_red_r;
    out_green_nxt     = out_green_r;
    out_blue_nxt      = out_blue_r;
    out_landed_nxt    = out_landed_r;
    mem_we            = 1'b0;
    mem_waddr         = cell_addr(cur_x_r, cur_y_r);
    mem_wdata         = '0;
    rd_en             = 1'b0;
    rd_addr           = cell_addr(cur_x_r, cur_y_r);
    div_req.start     = 1'b0;
    div_req.landed    = landed_r;
    div_req.divisor   = tp_eff;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:   grid_width_nxt   = cfg_wdata[DIM_W-1:0];
        CFG_GRID_HEIGHT:  grid_height_nxt  = cfg_wdata[DIM_W-1:0];
        CFG_TOTAL_POINTS: total_points_nxt = cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == {ADDR_W{1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          req_nxt = in_req_type;
          dir_nxt = in_direction;
          if (in_req_type == REQ_WALK) begin
            cur_x_nxt         = wx_sat;
            cur_y_nxt         = wy_sat;
            walker_x_nxt      = wx_sat;
            walker_y_nxt      = wy_sat;
            walker_active_nxt = 1'b1;
          end else begin
            cur_x_nxt = px_sat;
            cur_y_nxt = py_sat;
          end
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        // Neighbor and margin test for a walk; seeds are written here directly.
        nx_nxt = cur_x_r;
        ny_nxt = cur_y_r;
        case (dir_r)
          DIR_LEFT: begin
            held_nxt = (cur_x_r <= COORD_W'(1));
            nx_nxt   = cur_x_r - COORD_W'(1);
          end
          DIR_UP: begin
            held_nxt = (cur_y_r <= COORD_W'(1));
            ny_nxt   = cur_y_r - COORD_W'(1);
          end
          DIR_RIGHT: begin
            held_nxt = ({1'b0, cur_x_r} >= w_eff - DIM_W'(1));
            nx_nxt   = cur_x_r + COORD_W'(1);
          end
          default: begin
            held_nxt = ({1'b0, cur_y_r} >= h_eff - DIM_W'(1));
            ny_nxt   = cur_y_r + COORD_W'(1);
          end
        endcase
        if (req_r == REQ_SEED) begin
          mem_we    = 1'b1;
          mem_wdata = CELL_FULL;
          val_nxt   = CELL_FULL;
          stat_nxt  = STAT_SEEDED;
          state_nxt = ST_DONE;
        end else begin
          rd_en     = 1'b1;
          state_nxt = ST_OWN;
        end
      end
      ST_OWN: begin
        if (req_r != REQ_WALK) begin
          val_nxt   = rdata_r;
          stat_nxt  = STAT_READ;
          state_nxt = ST_DONE;
        end else if (rdata_r != '0) begin
          stat_nxt      = STAT_LANDED_INSIDE;
          div_req.start = 1'b1;
          state_nxt     = ST_DIV;
        end else if (held_r) begin
          val_nxt   = '0;
          stat_nxt  = STAT_HELD;
          state_nxt = ST_DONE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = cell_addr(nx_r, ny_r);
          state_nxt = ST_NBR;
        end
      end
      ST_NBR: begin
        if (rdata_r != '0) begin
          stat_nxt      = STAT_LANDED;
          div_req.start = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          val_nxt      = '0;
          stat_nxt     = STAT_MOVED;
          cur_x_nxt    = nx_r;
          cur_y_nxt    = ny_r;
          walker_x_nxt = nx_r;
          walker_y_nxt = ny_r;
          state_nxt    = ST_DONE;
        end
      end
      ST_DIV: begin
        // The walker lands on its current cell with the scaled landing count.
        if (div_rsp.done) begin
          mem_we            = 1'b1;
          mem_wdata         = div_rsp.quotient;
          val_nxt           = div_rsp.quotient;
          walker_active_nxt = 1'b0;
          if (landed_r < tp_eff) begin
            landed_nxt = landed_r + COUNT_W'(1);
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = stat_r;
          out_col_nxt    = cur_x_r;
          out_row_nxt    = cur_y_r;
          out_val_nxt    = val_r;
          out_red_nxt    = red_c;
          out_green_nxt  = green_c;
          out_blue_nxt   = blue_c;
          out_landed_nxt = landed_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_CLEAR;
      clr_addr_r      <= '0;
      grid_width_r    <= RST_GRID_WIDTH;
      grid_height_r   <= RST_GRID_HEIGHT;
      total_points_r  <= RST_TOTAL_POINTS;
      walker_x_r      <= '0;
      walker_y_r      <= '0;
      walker_active_r <= 1'b0;
      landed_r        <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      clr_addr_r      <= clr_addr_nxt;
      grid_width_r    <= grid_width_nxt;
      grid_height_r   <= grid_height_nxt;
      total_points_r  <= total_points_nxt;
      walker_x_r      <= walker_x_nxt;
      walker_y_r      <= walker_y_nxt;
      walker_active_r <= walker_active_nxt;
      landed_r        <= landed_nxt;
      out_valid_r     <= out_valid_nxt;
    end
    req_r        <= req_nxt;
    dir_r        <= dir_nxt;
    cur_x_r      <= cur_x_nxt;
    cur_y_r      <= cur_y_nxt;
    nx_r         <= nx_nxt;
    ny_r         <= ny_nxt;
    held_r       <= held_nxt;
    val_r        <= val_nxt;
    stat_r       <= stat_nxt;
    out_status_r <= out_status_nxt;
    out_col_r    <= out_col_nxt;
    out_row_r    <= out_row_nxt;
    out_val_r    <= out_val_nxt;
    out_red_r    <= out_red_nxt;
    out_green_r  <= out_green_nxt;
    out_blue_r   <= out_blue_nxt;
    out_landed_r <= out_landed_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_walker_col    = out_col_r;
  assign out_walker_row    = out_row_r;
  assign out_cell_value    = out_val_r;
  assign out_red           = out_red_r;
  assign out_green         = out_green_r;
  assign out_blue          = out_blue_r;
  assign out_landed_so_far = out_landed_r;

`ifndef SYNTHESIS
  // The divider answers only while the engine waits for a landing value.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV))
    else $error("landing divider answered outside the landing wait");

  // The grid is written only by the clearing pass, a seed or a landing.
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_CLEAR || state_r == ST_LOOK || state_r == ST_DIV))
    else $error("grid written outside clear, seed or landing");

  // The landed count only ever steps up by one, and only on a landing.
  a_landed_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (landed_r != $past(landed_r))) |->
      ((landed_r == $past(landed_r) + 16'd1) && ($past(state_r) == ST_DIV)))
    else $error("landed count changed other than by a landing");

  // The walker is retired only by a landing.
  a_walker_retire: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(walker_active_r)) |-> ($past(state_r) == ST_DIV))
    else $error("walker retired without landing");
`endif

endmodule
